FILE: src/tfcs_pkg.sv
package tfcs_pkg;

  localparam int TS_W      = 48;
  localparam int SEQ_W     = 32;
  localparam int VOLT_W    = 18;
  localparam int TEMP_W    = 13;
  localparam int GPS_W     = 8;
  localparam int SATS_W    = 8;
  localparam int COUNT_W   = 16;
  localparam int LOWV_W    = 17;
  localparam int TOTAL_W   = 29;
  localparam int RATE_W    = 32;
  localparam int STATUS_W  = 4;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 120;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam int DIVIDEND_W = 36;
  localparam int DIVISOR_W  = 48;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [19:0] RATE_SCALE = 20'd1000000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_VOLTAGE     = 4'd1,
    ST_TEMPERATURE = 4'd2,
    ST_GPS         = 4'd3,
    ST_SATELLITES  = 4'd4,
    ST_TIMESTAMP   = 4'd5,
    ST_SEQUENCE    = 4'd6,
    ST_TOO_MANY    = 4'd7,
    ST_TOO_FEW     = 4'd8
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOW_VOLTAGE = 2'd0,
    REG_TEMP_MIN    = 2'd1,
    REG_TEMP_MAX    = 2'd2,
    REG_MAX_FRAMES  = 2'd3
  } cfg_reg_t;

  localparam logic [LOWV_W-1:0]   LOW_VOLTAGE_RST = 17'd22000;
  localparam logic [TEMP_W-1:0]   TEMP_MIN_RST    = 13'h1E70;
  localparam logic [TEMP_W-1:0]   TEMP_MAX_RST    = 13'd1200;
  localparam logic [COUNT_W-1:0]  MAX_FRAMES_RST  = 16'd1024;

  typedef struct packed {
    logic frame;
    logic avg_start;
    logic avg_take;
    logic rate_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic summary;
    logic out_full;
    logic div_done;
  } sts_t;

endpackage

FILE: src/tfcs_div.sv
module tfcs_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tfcs_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [tfcs_pkg::DIVISOR_W-1:0]      divisor,
  output logic [tfcs_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                                done
);

  logic [tfcs_pkg::DIVIDEND_W-1:0] quo_r;
  logic [tfcs_pkg::DIVISOR_W-1:0]  rem_r;
  logic [tfcs_pkg::DIVISOR_W-1:0]  dvs_r;
  logic [tfcs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [tfcs_pkg::DIVISOR_W:0]    rem_shift;
  logic                            ge;
  logic [tfcs_pkg::DIVISOR_W:0]    rem_sub;
  logic [tfcs_pkg::DIVISOR_W-1:0]  rem_nxt;

  assign rem_shift = {rem_r, quo_r[tfcs_pkg::DIVIDEND_W-1]};
  assign ge        = rem_shift >= {1'b0, dvs_r};
  assign rem_sub   = rem_shift - {1'b0, dvs_r};
  assign rem_nxt   = ge ? rem_sub[tfcs_pkg::DIVISOR_W-1:0]
                        : rem_shift[tfcs_pkg::DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[tfcs_pkg::DIVIDEND_W-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tfcs_pkg::DIV_CNT_W'(tfcs_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: src/tfcs_dp.sv
module tfcs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tfcs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [tfcs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [tfcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tfcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  tfcs_pkg::cmd_t                     cmd,
  output tfcs_pkg::sts_t                     sts
);

  logic [tfcs_pkg::TS_W-1:0]          ts;
  logic [tfcs_pkg::SEQ_W-1:0]         seq;
  logic signed [tfcs_pkg::VOLT_W-1:0] volt;
  logic signed [tfcs_pkg::TEMP_W-1:0] temp;
  logic [tfcs_pkg::GPS_W-1:0]         gps;
  logic signed [tfcs_pkg::SATS_W-1:0] sats;

  assign ts   = in_tdata[47:0];
  assign seq  = in_tdata[79:48];
  assign volt = in_tdata[97:80];
  assign temp = in_tdata[110:98];
  assign gps  = in_tdata[118:111];
  assign sats = in_tdata[126:119];

  logic [tfcs_pkg::LOWV_W-1:0]         low_voltage_r;
  logic signed [tfcs_pkg::TEMP_W-1:0]  temp_min_r;
  logic signed [tfcs_pkg::TEMP_W-1:0]  temp_max_r;
  logic [tfcs_pkg::COUNT_W-1:0]        max_frames_r;

  logic [tfcs_pkg::COUNT_W-1:0]        count_r;
  logic [tfcs_pkg::TS_W-1:0]           first_ts_r;
  logic [tfcs_pkg::TS_W-1:0]           prev_ts_r;
  logic [tfcs_pkg::SEQ_W-1:0]          prev_seq_r;
  logic signed [tfcs_pkg::VOLT_W-1:0]  vmin_r;
  logic signed [tfcs_pkg::VOLT_W-1:0]  vmax_r;
  logic [tfcs_pkg::COUNT_W-1:0]        low_r;
  logic [tfcs_pkg::TOTAL_W-1:0]        total_r;
  logic                                failed_r;
  logic [tfcs_pkg::DIVIDEND_W-1:0]     prod_r;
  logic [tfcs_pkg::TEMP_W-1:0]         avg_r;

  logic                                out_valid_r;
  logic [tfcs_pkg::STATUS_W-1:0]       o_status_r;
  logic [tfcs_pkg::COUNT_W-1:0]        o_count_r;
  logic [tfcs_pkg::VOLT_W-1:0]         o_vmin_r;
  logic [tfcs_pkg::VOLT_W-1:0]         o_vmax_r;
  logic [tfcs_pkg::TEMP_W-1:0]         o_avg_r;
  logic [tfcs_pkg::COUNT_W-1:0]        o_low_r;
  logic [tfcs_pkg::RATE_W-1:0]         o_rate_r;

  tfcs_pkg::status_t                   chk;
  logic [tfcs_pkg::COUNT_W-1:0]        count_inc;
  logic [tfcs_pkg::COUNT_W-1:0]        count_m1;
  logic [tfcs_pkg::TOTAL_W-1:0]        temp_ext;
  logic [tfcs_pkg::TOTAL_W-1:0]        total_abs;
  logic [tfcs_pkg::TS_W-1:0]           elapsed;
  logic                                frame_ok;
  logic                                early_emit;

  logic                                div_start;
  logic [tfcs_pkg::DIVIDEND_W-1:0]     div_dividend;
  logic [tfcs_pkg::DIVISOR_W-1:0]      div_divisor;
  logic [tfcs_pkg::DIVIDEND_W-1:0]     div_quotient;
  logic                                div_done;
  logic [tfcs_pkg::RATE_W-1:0]         rate;

  always_comb begin
    chk = tfcs_pkg::ST_OK;
    if (count_r >= max_frames_r) begin
      chk = tfcs_pkg::ST_TOO_MANY;
    end else if (volt <= 18'sd0) begin
      chk = tfcs_pkg::ST_VOLTAGE;
    end else if (temp < temp_min_r || temp > temp_max_r) begin
      chk = tfcs_pkg::ST_TEMPERATURE;
    end else if (|gps[tfcs_pkg::GPS_W-1:1]) begin
      chk = tfcs_pkg::ST_GPS;
    end else if (sats < 8'sd0) begin
      chk = tfcs_pkg::ST_SATELLITES;
    end else if (count_r != '0 && ts <= prev_ts_r) begin
      chk = tfcs_pkg::ST_TIMESTAMP;
    end else if (count_r != '0 && seq != prev_seq_r + 32'd1) begin
      chk = tfcs_pkg::ST_SEQUENCE;
    end
  end

  assign count_inc  = count_r + 16'd1;
  assign count_m1   = count_r - 16'd1;
  assign temp_ext   = {{(tfcs_pkg::TOTAL_W - tfcs_pkg::TEMP_W){temp[tfcs_pkg::TEMP_W-1]}}, temp};
  assign total_abs  = total_r[tfcs_pkg::TOTAL_W-1] ? (~total_r + 1'b1) : total_r;
  assign elapsed    = prev_ts_r - first_ts_r;
  assign frame_ok   = !failed_r && chk == tfcs_pkg::ST_OK;
  assign early_emit = !failed_r && (chk != tfcs_pkg::ST_OK || (in_tlast && count_r == '0));

  assign sts.summary  = frame_ok && in_tlast && count_r != '0;
  assign sts.out_full = out_valid_r;
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_voltage_r <= tfcs_pkg::LOW_VOLTAGE_RST;
      temp_min_r    <= tfcs_pkg::TEMP_MIN_RST;
      temp_max_r    <= tfcs_pkg::TEMP_MAX_RST;
      max_frames_r  <= tfcs_pkg::MAX_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        tfcs_pkg::REG_LOW_VOLTAGE: low_voltage_r <= cfg_wdata;
        tfcs_pkg::REG_TEMP_MIN:    temp_min_r    <= cfg_wdata[tfcs_pkg::TEMP_W-1:0];
        tfcs_pkg::REG_TEMP_MAX:    temp_max_r    <= cfg_wdata[tfcs_pkg::TEMP_W-1:0];
        tfcs_pkg::REG_MAX_FRAMES:  max_frames_r  <= cfg_wdata[tfcs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      low_r    <= '0;
      total_r  <= '0;
      failed_r <= 1'b0;
    end else if (cmd.frame) begin
      if (failed_r) begin
        if (in_tlast) begin
          count_r  <= '0;
          low_r    <= '0;
          total_r  <= '0;
          failed_r <= 1'b0;
        end
      end else if (chk != tfcs_pkg::ST_OK) begin
        if (in_tlast) begin
          count_r <= '0;
          low_r   <= '0;
          total_r <= '0;
        end else begin
          failed_r <= 1'b1;
        end
      end else if (in_tlast && count_r == '0) begin
        count_r <= '0;
        low_r   <= '0;
        total_r <= '0;
      end else begin
        count_r    <= count_inc;
        total_r    <= total_r + temp_ext;
        prev_ts_r  <= ts;
        prev_seq_r <= seq;
        if ($unsigned(volt) < {1'b0, low_voltage_r}) begin
          low_r <= low_r + 16'd1;
        end
        if (count_r == '0) begin
          first_ts_r <= ts;
          vmin_r     <= volt;
          vmax_r     <= volt;
        end else begin
          if (volt < vmin_r) begin
            vmin_r <= volt;
          end
          if (volt > vmax_r) begin
            vmax_r <= volt;
          end
        end
      end
    end else if (cmd.finish) begin
      count_r <= '0;
      low_r   <= '0;
      total_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_start) begin
      prod_r <= tfcs_pkg::DIVIDEND_W'(count_m1)
                * tfcs_pkg::DIVIDEND_W'(tfcs_pkg::RATE_SCALE);
    end
    if (cmd.avg_take) begin
      avg_r <= total_r[tfcs_pkg::TOTAL_W-1] ? (~div_quotient[tfcs_pkg::TEMP_W-1:0] + 1'b1)
                                            : div_quotient[tfcs_pkg::TEMP_W-1:0];
    end
  end

  assign div_start    = cmd.avg_start | cmd.rate_start;
  assign div_dividend = cmd.avg_start
                        ? {{(tfcs_pkg::DIVIDEND_W - tfcs_pkg::TOTAL_W){1'b0}}, total_abs}
                        : prod_r;
  assign div_divisor  = cmd.avg_start
                        ? {{(tfcs_pkg::DIVISOR_W - tfcs_pkg::COUNT_W){1'b0}}, count_r}
                        : elapsed;

  tfcs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  assign rate = (elapsed == '0) ? '0 :
                (|div_quotient[tfcs_pkg::DIVIDEND_W-1:tfcs_pkg::RATE_W]) ? '1 :
                div_quotient[tfcs_pkg::RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.frame && early_emit) begin
        out_valid_r <= 1'b1;
        o_vmin_r    <= '0;
        o_vmax_r    <= '0;
        o_avg_r     <= '0;
        o_low_r     <= '0;
        o_rate_r    <= '0;
        if (chk != tfcs_pkg::ST_OK) begin
          o_status_r <= chk;
          o_count_r  <= count_r;
        end else begin
          o_status_r <= tfcs_pkg::ST_TOO_FEW;
          o_count_r  <= count_inc;
        end
      end else if (cmd.finish) begin
        out_valid_r <= 1'b1;
        o_status_r  <= tfcs_pkg::ST_OK;
        o_count_r   <= count_r;
        o_vmin_r    <= vmin_r;
        o_vmax_r    <= vmax_r;
        o_avg_r     <= avg_r;
        o_low_r     <= low_r;
        o_rate_r    <= rate;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_rate_r, o_low_r, o_avg_r, o_vmax_r, o_vmin_r,
                       o_count_r, o_status_r};

endmodule

FILE: src/tfcs_ctrl.sv
module tfcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            out_tready,
  input  tfcs_pkg::sts_t  sts,
  output logic            in_tready,
  output tfcs_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_AVG,
    S_AVG_WAIT,
    S_RATE_WAIT
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && (!sts.out_full || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd            = '0;
    cmd.frame      = accept;
    cmd.avg_start  = (state_r == S_AVG);
    cmd.avg_take   = (state_r == S_AVG_WAIT) && sts.div_done;
    cmd.rate_start = (state_r == S_AVG_WAIT) && sts.div_done;
    cmd.finish     = (state_r == S_RATE_WAIT) && sts.div_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && sts.summary) begin
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          state_r <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (sts.div_done) begin
            state_r <= S_RATE_WAIT;
          end
        end
        S_RATE_WAIT: begin
          if (sts.div_done) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/telemetry_frame_checker_stats.sv
// Checks parsed telemetry frames and gathers statistics over one data set.
// Frames enter on the in_ stream, one transfer per frame; in_tlast marks the
// last frame of the set. Results leave on the out_ stream, at most one
// transfer per frame: an error status on the first failing frame, or a
// summary (or a too-few status) on the last frame of the set.
// A frame that passes and is not last produces no result, so such frames
// stream at one per cycle while no result is stalled. An error or too-few
// result is registered and appears in the cycle after its frame. A summary
// needs two 36-step divisions on a shared one-bit-per-cycle divider and
// appears when the second one is done; in_tready stays low until then.
// A single output register holds the pending result. While it is occupied
// and out_tready is low, in_tready is low as well; the block accepts the
// next frame in the cycle the result is taken.
// The cfg_ port writes the thresholds and the frame limit; write only
// while the block is idle. Reset (rst_n low, synchronous) restores the
// register defaults, empties the output and starts a fresh data set.
module telemetry_frame_checker_stats (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // time_stamp, seq_number, voltage_mv, temperature, gps_fix, satellites
  input  logic [tfcs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, frame_total, voltage_min_out, voltage_max_out,
  // temperature_avg_tenths, low_voltage_count, frame_rate_mhz
  output logic [tfcs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [tfcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tfcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  tfcs_pkg::cmd_t cmd;
  tfcs_pkg::sts_t sts;

  tfcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  tfcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: src/tfcs_checker.sv
module tfcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tfcs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic [tfcs_pkg::STATUS_W-1:0] status;
  logic [tfcs_pkg::COUNT_W-1:0]  frame_total;

  assign status      = out_tdata[3:0];
  assign frame_total = out_tdata[19:4];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or vanished while stalled");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("frame taken while result register is stalled");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != tfcs_pkg::ST_OK |-> out_tdata[116:20] == '0)
    else $error("error result carries statistics");

  a_too_few_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == tfcs_pkg::ST_TOO_FEW |-> frame_total == 16'd1)
    else $error("too-few result with wrong frame count");

  a_summary_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == tfcs_pkg::ST_OK |-> frame_total >= 16'd2)
    else $error("summary with fewer than two frames");

endmodule

bind telemetry_frame_checker_stats tfcs_checker u_tfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
